// ===== hdl/wbrle_pkg.sv =====
// Shared constants, types and descriptor layout for the wide block run-length encoder.
`timescale 1ns / 1ps

package wbrle_pkg;

    localparam int MAX_WORDS = 4;
    localparam int WORD_W = 64;
    localparam int WSEL_W = $clog2(MAX_WORDS);
    localparam int DEFAULT_WORDS_PER_BLOCK = 4;
    localparam int DESC_DEPTH = 4;
    localparam logic [WORD_W-1:0] RUN_MARKER = 64'h372E934ACB2BF3D1;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        KIND_LIT1,
        KIND_LIT2,
        KIND_RUN
    } desc_kind_t;

    typedef struct packed {
        word_t [MAX_WORDS-1:0] words;
        word_t                 count;
        desc_kind_t            kind;
        logic                  last;
    } desc_t;

    typedef struct packed {
        logic [1:0] num;
        desc_t      first;
        desc_t      second;
    } desc_push_t;

endpackage

// ===== hdl/wbrle_if.sv =====
// Request channel interfaces for input blocks and encoded output words.
`timescale 1ns / 1ps

interface wbrle_block_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_word0;
    logic [63:0] block_word1;
    logic [63:0] block_word2;
    logic [63:0] block_word3;
    logic        final_block;

    modport source (
        output valid, block_word0, block_word1, block_word2, block_word3, final_block,
        input  ready
    );
    modport sink (
        input  valid, block_word0, block_word1, block_word2, block_word3, final_block,
        output ready
    );
endinterface

interface wbrle_code_if;
    logic        valid;
    logic        ready;
    logic [63:0] coded_word;
    logic        stream_end;

    modport source (
        output valid, coded_word, stream_end,
        input  ready
    );
    modport sink (
        input  valid, coded_word, stream_end,
        output ready
    );
endinterface

// ===== hdl/wbrle_lane.sv =====
// One compare lane: holds one word of the current block and matches it against the input.
`timescale 1ns / 1ps

module wbrle_lane
    import wbrle_pkg::*;
(
    input  logic  clk,
    input  logic  load,
    input  word_t in_word,
    output word_t held_word,
    output logic  match
);

    word_t held_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_reg <= in_word;
        end
    end

    assign held_word = held_reg;
    assign match = (in_word == held_reg);

endmodule

// ===== hdl/wbrle_serializer.sv =====
// Descriptor queue and word serializer that drives the registered output channel.
`timescale 1ns / 1ps

module wbrle_serializer
    import wbrle_pkg::*;
#(
    parameter int WORDS_PER_BLOCK = DEFAULT_WORDS_PER_BLOCK
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  desc_push_t push,
    output logic       space,
    wbrle_code_if.source code
);

    localparam int N = WORDS_PER_BLOCK;
    localparam int IDX_W = $clog2(2 * N);
    localparam int PTR_W = $clog2(DESC_DEPTH);
    localparam int CNT_W = $clog2(DESC_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_LIT1 = IDX_W'(N - 1);
    localparam logic [IDX_W-1:0] LAST_LIT2 = IDX_W'(2 * N - 1);
    localparam logic [IDX_W-1:0] LAST_RUN = IDX_W'(N + 1);
    localparam logic [IDX_W-1:0] IDX_COUNT = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_BLOCK = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_N = IDX_W'(N);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(DESC_DEPTH - 2);

    desc_t [DESC_DEPTH-1:0] queue_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    word_t            out_word_reg;
    logic             out_end_reg;

    desc_t            head;
    logic             have;
    logic             load;
    logic             at_last;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] sel;
    word_t            word_sel;

    assign head = queue_reg[rd_ptr_reg];
    assign have = (count_reg != '0);
    assign load = have && (!out_valid_reg || code.ready);
    assign space = (count_reg <= CNT_LIMIT);

    always_comb
    begin
        sel = idx_reg;
        last_idx = LAST_LIT1;
        word_sel = head.words[sel[WSEL_W-1:0]];
        case (head.kind)
            KIND_RUN:
            begin
                last_idx = LAST_RUN;
                sel = idx_reg - IDX_BLOCK;
                if (idx_reg == '0)
                begin
                    word_sel = RUN_MARKER;
                end
                else if (idx_reg == IDX_COUNT)
                begin
                    word_sel = head.count;
                end
                else
                begin
                    word_sel = head.words[sel[WSEL_W-1:0]];
                end
            end
            KIND_LIT2:
            begin
                last_idx = LAST_LIT2;
                sel = (idx_reg >= IDX_N) ? idx_reg - IDX_N : idx_reg;
                word_sel = head.words[sel[WSEL_W-1:0]];
            end
            default:
            begin
                last_idx = LAST_LIT1;
                sel = idx_reg;
                word_sel = head.words[sel[WSEL_W-1:0]];
            end
        endcase
    end

    assign at_last = (idx_reg == last_idx);
    assign count_next = count_reg + CNT_W'(push.num) - CNT_W'(load && at_last);

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
        if (load)
        begin
            out_word_reg <= word_sel;
            out_end_reg <= head.last && at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.num);
            count_reg <= count_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
                if (at_last)
                begin
                    idx_reg <= '0;
                    rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
                end
                else
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
            else if (code.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign code.valid = out_valid_reg;
    assign code.coded_word = out_word_reg;
    assign code.stream_end = out_end_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DESC_DEPTH))
        else $error("descriptor queue count exceeds its depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != 2'd0) |-> space)
        else $error("descriptor pushed while queue lacked room");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        have |-> idx_reg <= last_idx)
        else $error("word index ran past the end of its descriptor");

endmodule

// ===== hdl/wide_block_run_length_encoder.sv =====
// Top level of the wide block run-length encoder.
// Usage: blocks of WORDS_PER_BLOCK 64-bit words enter on the blk channel, one block
// per request; encoded 64-bit words leave on the code channel, one word per request.
// A block that differs from the held one releases the held block as WORDS_PER_BLOCK
// literal words (no repeat), twice as many literal words (one repeat) or a run of
// marker, count and block that is two words longer than the block (more repeats, or a
// first word equal to the marker). A request with final_block set flushes the pending
// block and flags its last word stream_end. The words of a release pass through the
// descriptor queue and then the output register. Throughput: one output word per cycle
// from the single-word output register while code.ready is high; a repeated block that
// is not final only raises the repeat count.
// A small descriptor queue sits between the compare lanes and the serializer, so
// new blocks are taken while earlier words still drain. blk.ready drops only when
// the queue cannot take two more releases; a stalled receiver just holds code.valid.
// Reset clears the held-block flag, the repeat count, the queue and the output valid flag.
`timescale 1ns / 1ps

module wide_block_run_length_encoder
    import wbrle_pkg::*;
#(
    parameter int WORDS_PER_BLOCK = DEFAULT_WORDS_PER_BLOCK
)
(
    input logic          clk,
    input logic          rst_n,
    wbrle_block_if.sink  blk,
    wbrle_code_if.source code
);

    localparam int N = WORDS_PER_BLOCK;

    word_t [MAX_WORDS-1:0] in_words;
    word_t [MAX_WORDS-1:0] held_words;
    logic  [N-1:0]         lane_match;
    logic                  accept;
    logic                  same;
    logic                  emit_held;
    logic                  space;
    logic                  held_valid_reg;
    word_t                 count_reg;
    word_t                 count_inc;
    word_t                 count_next;
    desc_t                 desc_held;
    desc_t                 desc_flush;
    desc_push_t            push;

    assign in_words[0] = blk.block_word0;
    assign in_words[1] = blk.block_word1;
    assign in_words[2] = blk.block_word2;
    assign in_words[3] = blk.block_word3;

    assign accept = blk.valid && blk.ready;
    assign blk.ready = space;

    genvar g;
    generate
        for (g = 0; g < MAX_WORDS; g++)
        begin : g_lane
            if (g < N)
            begin : g_used
                wbrle_lane u_lane (
                    .clk       (clk),
                    .load      (accept),
                    .in_word   (in_words[g]),
                    .held_word (held_words[g]),
                    .match     (lane_match[g])
                );
            end
            else
            begin : g_unused
                assign held_words[g] = in_words[g];
            end
        end
    endgenerate

    assign same = held_valid_reg && (&lane_match);
    assign emit_held = held_valid_reg && !same;
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 64'd1;
    assign count_next = same ? count_inc : '0;

    always_comb
    begin
        desc_held.words = held_words;
        desc_held.count = count_reg;
        desc_held.last = 1'b0;
        if (held_words[0] == RUN_MARKER || count_reg > 64'd1)
        begin
            desc_held.kind = KIND_RUN;
        end
        else if (count_reg == 64'd1)
        begin
            desc_held.kind = KIND_LIT2;
        end
        else
        begin
            desc_held.kind = KIND_LIT1;
        end

        desc_flush.words = in_words;
        desc_flush.count = count_next;
        desc_flush.last = 1'b1;
        if (in_words[0] == RUN_MARKER || (same && count_reg != '0))
        begin
            desc_flush.kind = KIND_RUN;
        end
        else if (same)
        begin
            desc_flush.kind = KIND_LIT2;
        end
        else
        begin
            desc_flush.kind = KIND_LIT1;
        end

        push.num = accept ? 2'(emit_held) + 2'(blk.final_block) : 2'd0;
        push.first = emit_held ? desc_held : desc_flush;
        push.second = desc_flush;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            held_valid_reg <= !blk.final_block;
            count_reg <= blk.final_block ? '0 : count_next;
        end
    end

    wbrle_serializer #(
        .WORDS_PER_BLOCK (WORDS_PER_BLOCK)
    ) u_serializer (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .space (space),
        .code  (code)
    );

endmodule
